// ----- rtl/first_fit_block_allocator_assert.svh -----
// assertion macros shared by the allocator rtl
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH

// condition holds at every edge out of reset
`define FFBA_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle
`define FFBA_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent holds in the next cycle
`define FFBA_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/ffba_pkg.sv -----
// shared constants and codes of the first-fit block allocator
`default_nettype none
package ffba_pkg;
    localparam int AREA_BYTES_DEF   = 4096;
    localparam int AREAS_DEF        = 4;
    localparam int HEADER_BYTES_DEF = 24;
    localparam int MAX_BLOCKS_DEF   = 64;

    localparam logic [11:0] MIN_SPLIT_RST = 12'd96;

    localparam logic [1:0] MODE_ALLOC   = 2'd0;
    localparam logic [1:0] MODE_FREE    = 2'd1;
    localparam logic [1:0] MODE_REALLOC = 2'd2;
    localparam logic [1:0] MODE_PREHEAT = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NULL   = 2'd1;
    localparam logic [1:0] ST_NOAREA = 2'd2;
    localparam logic [1:0] ST_BIG    = 2'd3;
endpackage
`default_nettype wire

// ----- rtl/first_fit_block_allocator.sv -----
// A request walks the block table of an area entry by entry (memory read, then
// evaluate); a split shifts the table tail entry by entry, and a free compacts
// the area entry by entry. One word is handled at a time: the next word is
// taken once the result is registered. The longest request is a realloc that
// locates, searches every area, splits, locates again and compacts.
// Reset clears area count, block counts and output valid; table needs no clear.
`default_nettype none
module first_fit_block_allocator import ffba_pkg::*; #(
    parameter int AREA_BYTES   = AREA_BYTES_DEF,
    parameter int AREAS        = AREAS_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF,
    parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // req_size[15:0], handle_area[17:16], handle_offset[29:18], area_count[32:30]
    input  wire logic [39:0] s_axis_tdata,
    // mode[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // status[1:0], out_area[3:2], out_offset[15:4], granted_size[27:16]
    output logic [31:0]      m_axis_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [11:0] cfg_data
);
    localparam int AW     = (AREAS > 1) ? $clog2(AREAS) : 1;
    localparam int CW     = $clog2(AREAS + 1);
    localparam int IW     = $clog2(MAX_BLOCKS);
    localparam int NW     = $clog2(MAX_BLOCKS + 1);
    localparam int LEN_W  = $clog2(AREA_BYTES);
    localparam int PW     = LEN_W + 1;
    localparam int ADDR_W = AW + IW;
    localparam int DATA_W = LEN_W + 1;
    localparam int FULL_LEN = AREA_BYTES - HEADER_BYTES;

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_A_START = 5'd1;
    localparam logic [4:0] S_A_RD    = 5'd2;
    localparam logic [4:0] S_A_EV    = 5'd3;
    localparam logic [4:0] S_A_NEW   = 5'd4;
    localparam logic [4:0] S_T_START = 5'd5;
    localparam logic [4:0] S_T_SHR   = 5'd6;
    localparam logic [4:0] S_T_SHW   = 5'd7;
    localparam logic [4:0] S_T_SPL   = 5'd8;
    localparam logic [4:0] S_T_SPL2  = 5'd9;
    localparam logic [4:0] S_A_OK    = 5'd10;
    localparam logic [4:0] S_L_RD    = 5'd11;
    localparam logic [4:0] S_L_EV    = 5'd12;
    localparam logic [4:0] S_M_START = 5'd13;
    localparam logic [4:0] S_M_LOAD  = 5'd14;
    localparam logic [4:0] S_M_RD    = 5'd15;
    localparam logic [4:0] S_M_EV    = 5'd16;
    localparam logic [4:0] S_M_FIN   = 5'd17;
    localparam logic [4:0] S_PRE     = 5'd18;
    localparam logic [4:0] S_DONE    = 5'd19;

    logic [4:0]       state_reg, state_next;
    logic [CW-1:0]    active_reg, active_next;
    logic [NW-1:0]    nblk_reg [AREAS];
    logic [NW-1:0]    nblk_next [AREAS];
    logic [11:0]      min_split_reg;
    logic             m_valid_reg, m_valid_next;
    logic [31:0]      m_data_reg, m_data_next;

    logic [1:0]       mode_reg, mode_next;
    logic [15:0]      size_reg, size_next;
    logic [1:0]       ha_reg, ha_next;
    logic [11:0]      ho_reg, ho_next;
    logic [2:0]       cnt_reg, cnt_next;
    logic             second_reg, second_next;
    logic [AW-1:0]    ar_reg, ar_next;
    logic [NW-1:0]    i_reg, i_next;
    logic [NW-1:0]    j_reg, j_next;
    logic [NW-1:0]    d_reg, d_next;
    logic [NW-1:0]    idx_reg, idx_next;
    logic [PW-1:0]    pos_reg, pos_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             cur_free_reg, cur_free_next;
    logic [LEN_W-1:0] cur_len_reg, cur_len_next;
    logic [1:0]       st_reg, st_next;
    logic [AW-1:0]    oa_reg, oa_next;
    logic [PW-1:0]    oo_reg, oo_next;
    logic [LEN_W-1:0] og_reg, og_next;

    logic              rd_en, wr_en;
    logic [ADDR_W-1:0] rd_addr, wr_addr;
    logic [DATA_W-1:0] rd_data, wr_data;
    logic              rd_free;
    logic [LEN_W-1:0]  rd_len;
    logic [NW-1:0]     n_cur;
    logic              zero_out;

    ffba_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (DATA_W)
    ) u_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    assign rd_free = rd_data[LEN_W];
    assign rd_len  = rd_data[LEN_W-1:0];
    assign n_cur   = nblk_reg[ar_reg];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign cfg_ready     = 1'b1;

    // results other than a granted block carry zero fields
    assign zero_out = (st_reg != ST_OK) || (mode_reg == MODE_FREE) || (mode_reg == MODE_PREHEAT);

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        active_next   = active_reg;
        nblk_next     = nblk_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        mode_next     = mode_reg;
        size_next     = size_reg;
        ha_next       = ha_reg;
        ho_next       = ho_reg;
        cnt_next      = cnt_reg;
        second_next   = second_reg;
        ar_next       = ar_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        d_next        = d_reg;
        idx_next      = idx_reg;
        pos_next      = pos_reg;
        len_next      = len_reg;
        cur_free_next = cur_free_reg;
        cur_len_next  = cur_len_reg;
        st_next       = st_reg;
        oa_next       = oa_reg;
        oo_next       = oo_reg;
        og_next       = og_reg;
        rd_en         = 1'b0;
        rd_addr       = '0;
        wr_en         = 1'b0;
        wr_addr       = '0;
        wr_data       = '0;

        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    mode_next   = s_axis_tuser;
                    size_next   = s_axis_tdata[15:0];
                    ha_next     = s_axis_tdata[17:16];
                    ho_next     = s_axis_tdata[29:18];
                    cnt_next    = s_axis_tdata[32:30];
                    second_next = 1'b0;
                    st_next     = ST_OK;
                    ar_next     = AW'(s_axis_tdata[17:16]);
                    i_next      = '0;
                    pos_next    = '0;
                    if (s_axis_tuser == MODE_ALLOC)
                    begin
                        state_next = S_A_START;
                    end
                    else if (s_axis_tuser == MODE_PREHEAT)
                    begin
                        state_next = S_PRE;
                    end
                    else if (s_axis_tdata[29:18] == 12'd0 && s_axis_tuser == MODE_REALLOC)
                    begin
                        state_next = S_A_START;
                    end
                    else if (s_axis_tdata[29:18] != 12'd0
                             && 32'(s_axis_tdata[17:16]) < 32'(active_reg))
                    begin
                        state_next = S_L_RD;
                    end
                    else
                    begin
                        st_next    = ST_NULL;
                        state_next = S_DONE;
                    end
                end
            end

            // first-fit search, newest area first
            S_A_START:
            begin
                i_next   = '0;
                pos_next = '0;
                if (size_reg == 16'd0)
                begin
                    st_next    = ST_NULL;
                    state_next = S_DONE;
                end
                else if (32'(size_reg) > 32'(FULL_LEN))
                begin
                    st_next    = ST_BIG;
                    state_next = S_DONE;
                end
                else if (active_reg == '0)
                begin
                    state_next = S_A_NEW;
                end
                else
                begin
                    ar_next    = AW'(active_reg - 1'b1);
                    state_next = S_A_RD;
                end
            end

            S_A_RD:
            begin
                if (i_reg < n_cur)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = {ar_reg, i_reg[IW-1:0]};
                    state_next = S_A_EV;
                end
                else if (ar_reg == '0)
                begin
                    state_next = S_A_NEW;
                end
                else
                begin
                    ar_next  = ar_reg - 1'b1;
                    i_next   = '0;
                    pos_next = '0;
                end
            end

            S_A_EV:
            begin
                if (rd_free && 32'(rd_len) >= 32'(size_reg))
                begin
                    idx_next   = i_reg;
                    len_next   = rd_len;
                    state_next = S_T_START;
                end
                else
                begin
                    pos_next   = PW'(32'(pos_reg) + 32'(HEADER_BYTES) + 32'(rd_len));
                    i_next     = i_reg + 1'b1;
                    state_next = S_A_RD;
                end
            end

            // bring up the next area as one free block
            S_A_NEW:
            begin
                if (32'(active_reg) >= 32'(AREAS))
                begin
                    st_next    = ST_NOAREA;
                    state_next = S_DONE;
                end
                else
                begin
                    wr_en       = 1'b1;
                    wr_addr     = {AW'(active_reg), IW'(0)};
                    wr_data     = {1'b1, LEN_W'(FULL_LEN)};
                    nblk_next[AW'(active_reg)] = NW'(1);
                    active_next = active_reg + 1'b1;
                    ar_next     = AW'(active_reg);
                    idx_next    = '0;
                    pos_next    = '0;
                    len_next    = LEN_W'(FULL_LEN);
                    state_next  = S_T_START;
                end
            end

            // take the block, split off the remainder when allowed
            S_T_START:
            begin
                if (32'(n_cur) < 32'(MAX_BLOCKS)
                    && 32'(len_reg) >= 32'(size_reg) + 32'(min_split_reg)
                    && 32'(len_reg) >= 32'(size_reg) + 32'(HEADER_BYTES))
                begin
                    j_next     = n_cur;
                    state_next = S_T_SHR;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = {ar_reg, idx_reg[IW-1:0]};
                    wr_data    = {1'b0, len_reg};
                    og_next    = len_reg;
                    state_next = S_A_OK;
                end
            end

            S_T_SHR:
            begin
                if (32'(j_reg) > 32'(idx_reg) + 32'd1)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = {ar_reg, IW'(j_reg - 1'b1)};
                    state_next = S_T_SHW;
                end
                else
                begin
                    state_next = S_T_SPL;
                end
            end

            S_T_SHW:
            begin
                wr_en      = 1'b1;
                wr_addr    = {ar_reg, j_reg[IW-1:0]};
                wr_data    = rd_data;
                j_next     = j_reg - 1'b1;
                state_next = S_T_SHR;
            end

            S_T_SPL:
            begin
                wr_en      = 1'b1;
                wr_addr    = {ar_reg, IW'(idx_reg + 1'b1)};
                wr_data    = {1'b1, LEN_W'(32'(len_reg) - 32'(size_reg) - 32'(HEADER_BYTES))};
                state_next = S_T_SPL2;
            end

            S_T_SPL2:
            begin
                wr_en      = 1'b1;
                wr_addr    = {ar_reg, idx_reg[IW-1:0]};
                wr_data    = {1'b0, LEN_W'(size_reg)};
                nblk_next[ar_reg] = n_cur + 1'b1;
                og_next    = LEN_W'(size_reg);
                state_next = S_A_OK;
            end

            S_A_OK:
            begin
                oa_next = ar_reg;
                oo_next = PW'(32'(pos_reg) + 32'(HEADER_BYTES));
                if (mode_reg == MODE_REALLOC && ho_reg != 12'd0)
                begin
                    second_next = 1'b1;
                    ar_next     = AW'(ha_reg);
                    i_next      = '0;
                    pos_next    = '0;
                    state_next  = S_L_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            // find the block whose payload starts at the handle offset
            S_L_RD:
            begin
                if (i_reg < n_cur)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = {ar_reg, i_reg[IW-1:0]};
                    state_next = S_L_EV;
                end
                else
                begin
                    if (!second_reg)
                    begin
                        st_next = ST_NULL;
                    end
                    state_next = S_DONE;
                end
            end

            S_L_EV:
            begin
                if (32'(pos_reg) + 32'(HEADER_BYTES) == 32'(ho_reg))
                begin
                    idx_next = i_reg;
                    len_next = rd_len;
                    if (second_reg || mode_reg == MODE_FREE)
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = {ar_reg, i_reg[IW-1:0]};
                        wr_data    = {1'b1, rd_len};
                        state_next = S_M_START;
                    end
                    else if (32'(rd_len) >= 32'(size_reg))
                    begin
                        oa_next    = ar_reg;
                        oo_next    = PW'(ho_reg);
                        og_next    = rd_len;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_A_START;
                    end
                end
                else
                begin
                    pos_next   = PW'(32'(pos_reg) + 32'(HEADER_BYTES) + 32'(rd_len));
                    i_next     = i_reg + 1'b1;
                    state_next = S_L_RD;
                end
            end

            // compact the area, joining runs of free blocks
            S_M_START:
            begin
                rd_en      = 1'b1;
                rd_addr    = {ar_reg, IW'(0)};
                i_next     = NW'(1);
                state_next = S_M_LOAD;
            end

            S_M_LOAD:
            begin
                cur_free_next = rd_free;
                cur_len_next  = rd_len;
                d_next        = '0;
                state_next    = S_M_RD;
            end

            S_M_RD:
            begin
                if (i_reg < n_cur)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = {ar_reg, i_reg[IW-1:0]};
                    state_next = S_M_EV;
                end
                else
                begin
                    state_next = S_M_FIN;
                end
            end

            S_M_EV:
            begin
                if (cur_free_reg && rd_free)
                begin
                    cur_len_next = LEN_W'(32'(cur_len_reg) + 32'(rd_len) + 32'(HEADER_BYTES));
                end
                else
                begin
                    wr_en         = 1'b1;
                    wr_addr       = {ar_reg, d_reg[IW-1:0]};
                    wr_data       = {cur_free_reg, cur_len_reg};
                    d_next        = d_reg + 1'b1;
                    cur_free_next = rd_free;
                    cur_len_next  = rd_len;
                end
                i_next     = i_reg + 1'b1;
                state_next = S_M_RD;
            end

            S_M_FIN:
            begin
                wr_en      = 1'b1;
                wr_addr    = {ar_reg, d_reg[IW-1:0]};
                wr_data    = {cur_free_reg, cur_len_reg};
                nblk_next[ar_reg] = d_reg + 1'b1;
                state_next = S_DONE;
            end

            // activate areas one per cycle
            S_PRE:
            begin
                if (cnt_reg == 3'd0)
                begin
                    state_next = S_DONE;
                end
                else if (32'(active_reg) >= 32'(AREAS))
                begin
                    st_next    = ST_NOAREA;
                    state_next = S_DONE;
                end
                else
                begin
                    wr_en       = 1'b1;
                    wr_addr     = {AW'(active_reg), IW'(0)};
                    wr_data     = {1'b1, LEN_W'(FULL_LEN)};
                    nblk_next[AW'(active_reg)] = NW'(1);
                    active_next = active_reg + 1'b1;
                    cnt_next    = cnt_reg - 1'b1;
                end
            end

            // hand the result word to the output register
            S_DONE:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    if (zero_out)
                    begin
                        m_data_next = {30'd0, st_reg};
                    end
                    else
                    begin
                        m_data_next = {4'd0, 12'(og_reg), 12'(oo_reg), 2'(oa_reg), st_reg};
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            active_reg    <= '0;
            m_valid_reg   <= 1'b0;
            min_split_reg <= MIN_SPLIT_RST;
            for (int k = 0; k < AREAS; k++)
            begin
                nblk_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            active_reg  <= active_next;
            m_valid_reg <= m_valid_next;
            nblk_reg    <= nblk_next;
            if (cfg_valid)
            begin
                min_split_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        m_data_reg   <= m_data_next;
        mode_reg     <= mode_next;
        size_reg     <= size_next;
        ha_reg       <= ha_next;
        ho_reg       <= ho_next;
        cnt_reg      <= cnt_next;
        second_reg   <= second_next;
        ar_reg       <= ar_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        d_reg        <= d_next;
        idx_reg      <= idx_next;
        pos_reg      <= pos_next;
        len_reg      <= len_next;
        cur_free_reg <= cur_free_next;
        cur_len_reg  <= cur_len_next;
        st_reg       <= st_next;
        oa_reg       <= oa_next;
        oo_reg       <= oo_next;
        og_reg       <= og_next;
    end

`include "first_fit_block_allocator_assert.svh"

    `FFBA_ALWAYS(a_active_range, 32'(active_reg) <= 32'(AREAS), "area count out of range")
    `FFBA_IMPLY(a_err_zero, m_axis_tvalid && m_axis_tdata[1:0] != ST_OK, m_axis_tdata[27:2] == 26'd0, "error word carries fields")
    `FFBA_IMPLY(a_wr_area, wr_en, 32'(wr_addr[ADDR_W-1:IW]) <= 32'(active_reg), "table write to inactive area")
    `FFBA_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "word taken while busy")
endmodule
`default_nettype wire

// ----- rtl/ffba_ram.sv -----
// block table memory, one write and one registered read port
`default_nettype none
module ffba_ram import ffba_pkg::*; #(
    parameter int ADDR_W = 8,
    parameter int DATA_W = 13
) (
    input  wire logic              clk,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data
);
    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

// ----- sim/first_fit_block_allocator_test.sv -----
// self-checking testbench for the first-fit block allocator
module first_fit_block_allocator_test;
    import ffba_pkg::*;

    localparam int AREA_BYTES   = AREA_BYTES_DEF;
    localparam int AREAS        = AREAS_DEF;
    localparam int HEADER_BYTES = HEADER_BYTES_DEF;
    localparam int MAX_BLOCKS   = MAX_BLOCKS_DEF;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 2 * (AREAS + 1) * MAX_BLOCKS + 20;

    // laid out as the result word, status in the lowest bits
    typedef struct packed {
        logic [11:0] granted;
        logic [11:0] offset;
        logic [1:0]  area;
        logic [1:0]  status;
    } grant_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [11:0] cfg_data;

    // allocator state mirror
    int unsigned split_min;
    int unsigned areas_on;
    int unsigned nblocks [AREAS];
    int unsigned blen [AREAS][MAX_BLOCKS];
    bit          bfree [AREAS][MAX_BLOCKS];

    grant_t grants_pending[$];
    int     error_count;
    int     words_sent;
    int     grants_seen;
    int     idle_cycles;
    bit     rx_stall_on;

    first_fit_block_allocator DUT (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report(input string what, input int unsigned got, input int unsigned want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // ---- mirror of the allocator ----
    function automatic void open_area();
        blen[areas_on][0]  = AREA_BYTES - HEADER_BYTES;
        bfree[areas_on][0] = 1'b1;
        nblocks[areas_on]  = 1;
        areas_on++;
    endfunction

    function automatic int unsigned payload_at(int unsigned a, int unsigned idx);
        int unsigned pos;
        pos = 0;
        for (int i = 0; i < idx; i++)
            pos += HEADER_BYTES + blen[a][i];
        return pos + HEADER_BYTES;
    endfunction

    function automatic int find_block(int unsigned a, int unsigned off);
        int unsigned pos;
        pos = 0;
        for (int i = 0; i < nblocks[a]; i++)
        begin
            if (pos + HEADER_BYTES == off)
                return i;
            pos += HEADER_BYTES + blen[a][i];
        end
        return -1;
    endfunction

    function automatic void coalesce(int unsigned a);
        int unsigned i;
        i = 0;
        while (i + 1 < nblocks[a])
        begin
            if (bfree[a][i] && bfree[a][i+1])
            begin
                blen[a][i] += blen[a][i+1] + HEADER_BYTES;
                for (int j = i + 1; j + 1 < nblocks[a]; j++)
                begin
                    blen[a][j]  = blen[a][j+1];
                    bfree[a][j] = bfree[a][j+1];
                end
                nblocks[a]--;
            end
            else
                i++;
        end
    endfunction

    function automatic void free_block(int unsigned a, int unsigned idx);
        bfree[a][idx] = 1'b1;
        for (int k = 0; k < areas_on; k++)
            coalesce(k);
    endfunction

    function automatic grant_t take(int unsigned a, int unsigned idx, int unsigned size);
        grant_t g;
        int unsigned n, len;
        n = nblocks[a];
        len = blen[a][idx];
        // split unless table full or remainder too small
        if (n < MAX_BLOCKS && len >= size + split_min && len >= size + HEADER_BYTES)
        begin
            for (int j = n; j > idx + 1; j--)
            begin
                blen[a][j]  = blen[a][j-1];
                bfree[a][j] = bfree[a][j-1];
            end
            blen[a][idx+1]  = len - size - HEADER_BYTES;
            bfree[a][idx+1] = 1'b1;
            blen[a][idx]    = size;
            nblocks[a]      = n + 1;
        end
        bfree[a][idx] = 1'b0;
        g.status  = ST_OK;
        g.area    = a[1:0];
        g.offset  = 12'(payload_at(a, idx));
        g.granted = 12'(blen[a][idx]);
        return g;
    endfunction

    function automatic grant_t first_fit(int unsigned size);
        grant_t g;
        g = '0;
        if (size == 0)
        begin
            g.status = ST_NULL;
            return g;
        end
        if (size > AREA_BYTES - HEADER_BYTES)
        begin
            g.status = ST_BIG;
            return g;
        end
        for (int a = areas_on; a > 0; a--)
            for (int i = 0; i < nblocks[a-1]; i++)
                if (bfree[a-1][i] && blen[a-1][i] >= size)
                    return take(a - 1, i, size);
        if (areas_on >= AREAS)
        begin
            g.status = ST_NOAREA;
            return g;
        end
        open_area();
        return take(areas_on - 1, 0, size);
    endfunction

    function automatic grant_t predict_grant(input logic [1:0] mode, input int unsigned size,
                                             input int unsigned ha, input int unsigned ho,
                                             input int unsigned cnt);
        grant_t g;
        int idx;
        g = '0;
        idx = -1;
        if ((mode == MODE_FREE || mode == MODE_REALLOC) && ho != 0 && ha < areas_on)
            idx = find_block(ha, ho);
        case (mode)
            MODE_ALLOC: g = first_fit(size);
            MODE_FREE:
                if (idx < 0) g.status = ST_NULL;
                else free_block(ha, idx);
            MODE_REALLOC:
                if (ho == 0) g = first_fit(size);
                else if (idx < 0) g.status = ST_NULL;
                else if (blen[ha][idx] >= size)
                begin
                    g.area    = ha[1:0];
                    g.offset  = ho[11:0];
                    g.granted = 12'(blen[ha][idx]);
                end
                else
                begin
                    g = first_fit(size);
                    if (g.status == ST_OK)
                    begin
                        idx = find_block(ha, ho);
                        if (idx >= 0) free_block(ha, idx);
                    end
                end
            default:
                for (int k = 0; k < cnt; k++)
                begin
                    if (areas_on >= AREAS)
                    begin
                        g.status = ST_NOAREA;
                        break;
                    end
                    open_area();
                end
        endcase
        if (g.status != ST_OK || mode == MODE_FREE || mode == MODE_PREHEAT)
            g = '{status: g.status, area: 2'd0, offset: 12'd0, granted: 12'd0};
        return g;
    endfunction

    // ---- stimulus ----
    task automatic send_word(input logic [1:0] mode, input int unsigned size,
                             input int unsigned ha, input int unsigned ho,
                             input int unsigned cnt);
        int unsigned gap;
        gap = $urandom_range(0, 14) * $urandom_range(0, 1);
        // valid drops only while the sender idles
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {7'd0, cnt[2:0], ho[11:0], ha[1:0], size[15:0]};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        grants_pending.push_back(predict_grant(mode, size, ha, ho, cnt));
        words_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (grants_pending.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_split_min(input int unsigned v);
        wait_drained();
        cfg_data  <= v[11:0];
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        split_min = v & 12'hFFF;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // pick a handle of a live block, sometimes a bogus one
    task automatic pick_handle(output int unsigned ha, output int unsigned ho);
        int idx;
        if (areas_on == 0 || $urandom_range(0, 9) == 0)
        begin
            ha = $urandom_range(0, 3);
            ho = $urandom_range(0, 4095);
            return;
        end
        ha  = $urandom_range(0, areas_on - 1);
        idx = $urandom_range(0, nblocks[ha] - 1);
        ho  = payload_at(ha, idx);
    endtask

    function automatic int unsigned rand_size();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 65535);
            1:       return $urandom_range(1000, 4072);
            2:       return $urandom_range(4070, 4075);
            default: return $urandom_range(1, 200);
        endcase
    endfunction

    task automatic test_directed();
        send_word(MODE_ALLOC, 0, 0, 0, 0);
        send_word(MODE_ALLOC, 65535, 0, 0, 0);
        send_word(MODE_ALLOC, AREA_BYTES - HEADER_BYTES + 1, 0, 0, 0);
        send_word(MODE_FREE, 0, 0, 0, 0);
        send_word(MODE_FREE, 0, 3, 24, 0);
        send_word(MODE_ALLOC, 1, 0, 0, 0);
        send_word(MODE_ALLOC, 100, 0, 0, 0);
        send_word(MODE_REALLOC, 50, 0, 24, 0);
        send_word(MODE_REALLOC, 0, 0, 24, 0);
        send_word(MODE_REALLOC, 500, 0, 24, 0);
        send_word(MODE_REALLOC, 10, 0, 0, 0);
        send_word(MODE_REALLOC, 0, 0, 0, 0);
        send_word(MODE_FREE, 0, 0, 25, 0);
        send_word(MODE_FREE, 0, 0, 48, 0);
        send_word(MODE_FREE, 0, 0, 48, 0);
        send_word(MODE_ALLOC, AREA_BYTES - HEADER_BYTES, 0, 0, 0);
        send_word(MODE_PREHEAT, 0, 0, 0, 0);
        send_word(MODE_PREHEAT, 0, 0, 0, 2);
        send_word(MODE_PREHEAT, 0, 0, 0, 4);
        send_word(MODE_ALLOC, 4000, 0, 0, 0);
        send_word(MODE_ALLOC, 4072, 0, 0, 0);
        send_word(MODE_ALLOC, 4072, 0, 0, 0);
        send_word(MODE_REALLOC, 4000, 2, 4095, 7);
        send_word(MODE_PREHEAT, 16'hFFFF, 3, 4095, 7);
    endtask

    task automatic test_random(input int n);
        int unsigned ha, ho, r;
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                send_word(MODE_ALLOC, rand_size(), $urandom_range(0, 3),
                          $urandom_range(0, 4095), $urandom_range(0, 7));
            else if (r < 80)
            begin
                pick_handle(ha, ho);
                send_word(MODE_FREE, $urandom_range(0, 65535), ha, ho, $urandom_range(0, 7));
            end
            else if (r < 97)
            begin
                pick_handle(ha, ho);
                if ($urandom_range(0, 7) == 0) ho = 0;
                send_word(MODE_REALLOC, rand_size(), ha, ho, $urandom_range(0, 7));
            end
            else
                send_word(MODE_PREHEAT, $urandom_range(0, 65535), $urandom_range(0, 3),
                          $urandom_range(0, 4095), $urandom_range(0, 7));
        end
    endtask

    // many tiny blocks so the table fills and splits get skipped
    task automatic test_full_table();
        for (int k = 0; k < 150; k++)
            send_word(MODE_ALLOC, $urandom_range(1, 8), 0, 0, 0);
        test_random(50);
    endtask

    // ---- result checker ----
    always @(posedge clk)
    begin
        grant_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[27:0];
            grants_seen++;
            if (grants_pending.size() == 0)
                report("unexpected word", got, 0);
            else
            begin
                want = grants_pending.pop_front();
                if (got.status  != want.status)  report("status", got.status, want.status);
                if (got.area    != want.area)    report("out_area", got.area, want.area);
                if (got.offset  != want.offset)  report("out_offset", got.offset, want.offset);
                if (got.granted != want.granted) report("granted_size", got.granted, want.granted);
            end
        end
    end

    // receiver stalls, in bursts with calm stretches
    always @(negedge clk)
    begin
        if (idle_cycles > 0)
        begin
            idle_cycles--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (m_axis_tvalid && rx_stall_on) idle_cycles = $urandom_range(0, 14);
        end
    end

    // watchdog on cycles without any transfer
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready) || !s_axis_tvalid && grants_pending.size() == 0)
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        error_count = 0;
        words_sent = 0;
        grants_seen = 0;
        idle_cycles = 0;
        rx_stall_on = 1'b1;
        split_min = MIN_SPLIT_RST;
        areas_on = 0;
        foreach (nblocks[a]) nblocks[a] = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        write_split_min(0);
        test_random(300);
        rx_stall_on = 1'b0;
        write_split_min(4095);
        test_random(250);
        rx_stall_on = 1'b1;
        write_split_min(24);
        test_full_table();
        write_split_min($urandom_range(1, 300));
        test_random(350);
        write_split_min(MIN_SPLIT_RST);
        test_random(400);

        wait_drained();
        $display("covered %0d request words and %0d result words", words_sent, grants_seen);
        $display("alloc, free, realloc, preheat over split thresholds 0 to 4095");
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
